[sv/mic_pkg.sv]
// Package: shared widths, request codes, count tables and pipeline types.
`timescale 1ns / 1ps

package mic_pkg;

  localparam int ExpW = 5;
  localparam int IdxW = 13;
  localparam int DegW = 7;
  localparam int TetW = 19;
  localparam int CntW = 10;
  localparam int NDeg = 2 ** DegW;

  typedef enum logic [1:0] {
    ReqRank   = 2'd0,
    ReqUnrank = 2'd1,
    ReqCount  = 2'd2
  } req_e;

  typedef logic [TetW-1:0] tab_t [NDeg];

  function automatic tab_t build_tri();
    tab_t t;
    for (int n = 0; n < NDeg; n++) begin
      t[n] = TetW'((n * (n + 1)) / 2);
    end
    return t;
  endfunction

  function automatic tab_t build_tet();
    tab_t t;
    for (int n = 0; n < NDeg; n++) begin
      t[n] = TetW'((n * (n + 1) * (n + 2)) / 6);
    end
    return t;
  endfunction

  localparam tab_t TriTab = build_tri();
  localparam tab_t TetTab = build_tet();

  typedef struct packed {
    logic [1:0]      req;
    logic            three;
    logic [ExpW-1:0] ea;
    logic [ExpW-1:0] eb;
    logic [ExpW-1:0] ec;
    logic [IdxW-1:0] idx;
    logic [ExpW-1:0] dq;
    logic [DegW-1:0] deg;
    logic [IdxW-1:0] rest;
    logic [DegW-1:0] sub;
  } pipe_t;

  typedef struct packed {
    logic [IdxW-1:0] rank;
    logic [ExpW-1:0] a;
    logic [ExpW-1:0] b;
    logic [ExpW-1:0] c;
    logic [ExpW-1:0] deg;
    logic [CntW-1:0] cnt;
    logic [IdxW-1:0] upto;
    logic            oor;
  } rsp_t;

endpackage

[sv/mic_req_if.sv]
// Interface: request channel with valid/ready handshake.
`timescale 1ns / 1ps

interface mic_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [mic_pkg::ExpW-1:0]  exp_a;
  logic [mic_pkg::ExpW-1:0]  exp_b;
  logic [mic_pkg::ExpW-1:0]  exp_c;
  logic [mic_pkg::IdxW-1:0]  mono_index;
  logic [mic_pkg::ExpW-1:0]  degree_query;

  modport source (
    output valid, req_type, exp_a, exp_b, exp_c, mono_index, degree_query,
    input  ready
  );

  modport sink (
    input  valid, req_type, exp_a, exp_b, exp_c, mono_index, degree_query,
    output ready
  );
endinterface

[sv/mic_rsp_if.sv]
// Interface: result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface mic_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mic_pkg::IdxW-1:0]  rank;
  logic [mic_pkg::ExpW-1:0]  out_a;
  logic [mic_pkg::ExpW-1:0]  out_b;
  logic [mic_pkg::ExpW-1:0]  out_c;
  logic [mic_pkg::ExpW-1:0]  total_degree;
  logic [mic_pkg::CntW-1:0]  count_of_degree;
  logic [mic_pkg::IdxW-1:0]  count_upto;
  logic                      out_of_range;

  modport source (
    output valid, rank, out_a, out_b, out_c, total_degree, count_of_degree,
           count_upto, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, rank, out_a, out_b, out_c, total_degree, count_of_degree,
           count_upto, out_of_range,
    output ready
  );
endinterface

[sv/mic_search_step.sv]
// One bit of a binary degree search, with its pipeline register.
`timescale 1ns / 1ps

module mic_search_step #(
  parameter int BIT    = 0,
  parameter bit SECOND = 1'b0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mic_pkg::pipe_t pipe_i,
  output logic           valid_o,
  input  logic           ready_i,
  output mic_pkg::pipe_t pipe_o
);

  logic                         valid_q;
  mic_pkg::pipe_t               pipe_q;
  mic_pkg::pipe_t               pipe_d;
  logic [mic_pkg::DegW-1:0]     acc;
  logic [mic_pkg::DegW-1:0]     cand;
  logic [mic_pkg::TetW-1:0]     key;
  logic [mic_pkg::TetW-1:0]     thr;

  // First search: degree of the index (tetrahedral or triangular).
  // Second search: triangular degree of the remainder within a degree.
  always_comb begin
    pipe_d = pipe_i;
    if (SECOND) begin
      acc = pipe_i.sub;
      key = mic_pkg::TetW'(pipe_i.rest);
    end else begin
      acc = pipe_i.deg;
      key = mic_pkg::TetW'(pipe_i.idx);
    end
    cand = acc | mic_pkg::DegW'(1 << BIT);
    if (SECOND || !pipe_i.three) begin
      thr = mic_pkg::TriTab[cand];
    end else begin
      thr = mic_pkg::TetTab[cand];
    end
    if (thr <= key) begin
      acc = cand;
    end
    if (SECOND) begin
      pipe_d.sub = acc;
    end else begin
      pipe_d.deg = acc;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

[sv/mic_result.sv]
// Final stage: rank, exponent split, counts and range check, output register.
`timescale 1ns / 1ps

module mic_result #(
  parameter int MAX_DEGREE = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mic_pkg::pipe_t pipe_i,
  output logic           valid_o,
  input  logic           ready_i,
  output mic_pkg::rsp_t  rsp_o
);

  localparam logic [mic_pkg::DegW-1:0] MaxDeg = mic_pkg::DegW'(MAX_DEGREE);

  logic                      valid_q;
  mic_pkg::rsp_t             rsp_q;
  mic_pkg::rsp_t             rsp_d;
  logic [mic_pkg::DegW-1:0]  dsum;
  logic [mic_pkg::DegW-1:0]  bc;
  logic [mic_pkg::DegW-1:0]  dq1;
  logic [mic_pkg::IdxW-1:0]  jsub;
  logic [mic_pkg::TetW-1:0]  rank3;
  logic [mic_pkg::TetW-1:0]  rank2;
  logic [mic_pkg::TetW-1:0]  cnt_w;
  logic [mic_pkg::TetW-1:0]  upto_w;

  always_comb begin
    dsum  = mic_pkg::DegW'(pipe_i.ea) + mic_pkg::DegW'(pipe_i.eb)
          + mic_pkg::DegW'(pipe_i.ec);
    bc    = mic_pkg::DegW'(pipe_i.eb) + mic_pkg::DegW'(pipe_i.ec);
    dq1   = mic_pkg::DegW'(pipe_i.dq) + mic_pkg::DegW'(1);
    jsub  = pipe_i.rest - mic_pkg::IdxW'(mic_pkg::TriTab[pipe_i.sub]);
    rank3 = mic_pkg::TetTab[dsum] + mic_pkg::TriTab[bc] + mic_pkg::TetW'(pipe_i.ec);
    rank2 = mic_pkg::TriTab[dsum] + mic_pkg::TetW'(pipe_i.eb);
    if (pipe_i.three) begin
      cnt_w  = mic_pkg::TriTab[dq1];
      upto_w = mic_pkg::TetTab[dq1];
    end else begin
      cnt_w  = mic_pkg::TetW'(dq1);
      upto_w = mic_pkg::TriTab[dq1];
    end

    rsp_d = '0;
    case (pipe_i.req)
      mic_pkg::ReqRank: begin
        if (dsum > MaxDeg) begin
          rsp_d.oor = 1'b1;
        end else begin
          rsp_d.rank = pipe_i.three ? mic_pkg::IdxW'(rank3) : mic_pkg::IdxW'(rank2);
          rsp_d.deg  = mic_pkg::ExpW'(dsum);
        end
      end
      mic_pkg::ReqUnrank: begin
        if (pipe_i.deg > MaxDeg) begin
          rsp_d.oor = 1'b1;
        end else if (pipe_i.three) begin
          rsp_d.a   = mic_pkg::ExpW'(pipe_i.deg - pipe_i.sub);
          rsp_d.b   = mic_pkg::ExpW'(pipe_i.sub - jsub[mic_pkg::DegW-1:0]);
          rsp_d.c   = mic_pkg::ExpW'(jsub);
          rsp_d.deg = mic_pkg::ExpW'(pipe_i.deg);
        end else begin
          // remainder is the second exponent in two-variable mode
          rsp_d.a   = mic_pkg::ExpW'(pipe_i.deg - pipe_i.rest[mic_pkg::DegW-1:0]);
          rsp_d.b   = mic_pkg::ExpW'(pipe_i.rest);
          rsp_d.deg = mic_pkg::ExpW'(pipe_i.deg);
        end
      end
      mic_pkg::ReqCount: begin
        if (mic_pkg::DegW'(pipe_i.dq) > MaxDeg) begin
          rsp_d.oor = 1'b1;
        end else begin
          rsp_d.cnt  = mic_pkg::CntW'(cnt_w);
          rsp_d.upto = mic_pkg::IdxW'(upto_w);
          rsp_d.deg  = pipe_i.dq;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

[sv/monomial_index_exponent_convert.sv]
// Top level: graded monomial rank / unrank / count pipeline.
// Pipeline: 17 register stages, from the input register to the result register.
// Throughput: one request per cycle while no stage is stalled; the degree searches
// resolve one bit per pipeline stage (two 7-stage searches), every stage registered.
// Backpressure stalls each stage only when it is full, so bubbles collapse.
// Reset clears all stage valid bits and sets three_vars to 0.
`timescale 1ns / 1ps

module monomial_index_exponent_convert #(
  parameter int MAX_DEGREE = 31
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  mic_req_if.sink   req_i,
  mic_rsp_if.source rsp_o
);

  localparam int SrchEnd = mic_pkg::DegW;
  localparam int RestStg = mic_pkg::DegW + 1;
  localparam int LastStg = 2 * mic_pkg::DegW + 1;

  logic                      three_vars_q;
  logic                      vld  [LastStg+1];
  logic                      rdy  [LastStg+1];
  mic_pkg::pipe_t            pipe [LastStg+1];
  mic_pkg::pipe_t            in_d;
  mic_pkg::pipe_t            in_q;
  logic                      in_vld_q;
  mic_pkg::pipe_t            rest_d;
  mic_pkg::pipe_t            rest_q;
  logic                      rest_vld_q;
  logic [mic_pkg::TetW-1:0]  base;
  mic_pkg::rsp_t             rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_vars_q <= 1'b0;
    end else if (cfg_we_i) begin
      three_vars_q <= cfg_wdata_i;
    end
  end

  // Input stage: capture the request and the mode, drop exp_c in two-variable mode.
  always_comb begin
    in_d       = '0;
    in_d.req   = req_i.req_type;
    in_d.three = three_vars_q;
    in_d.ea    = req_i.exp_a;
    in_d.eb    = req_i.exp_b;
    in_d.ec    = three_vars_q ? req_i.exp_c : '0;
    in_d.idx   = req_i.mono_index;
    in_d.dq    = req_i.degree_query;
  end

  assign req_i.ready = !in_vld_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= in_d;
    end
  end

  assign vld[0]  = in_vld_q;
  assign pipe[0] = in_q;

  // Degree of the index, most significant bit first.
  for (genvar g = 0; g < mic_pkg::DegW; g++) begin : g_srch_deg
    mic_search_step #(
      .BIT    (mic_pkg::DegW - 1 - g),
      .SECOND (1'b0)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .pipe_i  (pipe[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .pipe_o  (pipe[g+1])
    );
  end

  // Remainder stage: offset of the index inside its degree.
  always_comb begin
    if (pipe[SrchEnd].three) begin
      base = mic_pkg::TetTab[pipe[SrchEnd].deg];
    end else begin
      base = mic_pkg::TriTab[pipe[SrchEnd].deg];
    end
    rest_d      = pipe[SrchEnd];
    rest_d.rest = mic_pkg::IdxW'(mic_pkg::TetW'(pipe[SrchEnd].idx) - base);
    rest_d.sub  = '0;
  end

  assign rdy[SrchEnd] = !rest_vld_q || rdy[RestStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_vld_q <= 1'b0;
    end else if (rdy[SrchEnd]) begin
      rest_vld_q <= vld[SrchEnd];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[SrchEnd] && vld[SrchEnd]) begin
      rest_q <= rest_d;
    end
  end

  assign vld[RestStg]  = rest_vld_q;
  assign pipe[RestStg] = rest_q;

  // Triangular degree of the remainder (split of the last two exponents).
  for (genvar g = 0; g < mic_pkg::DegW; g++) begin : g_srch_sub
    mic_search_step #(
      .BIT    (mic_pkg::DegW - 1 - g),
      .SECOND (1'b1)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[RestStg+g]),
      .ready_o (rdy[RestStg+g]),
      .pipe_i  (pipe[RestStg+g]),
      .valid_o (vld[RestStg+g+1]),
      .ready_i (rdy[RestStg+g+1]),
      .pipe_o  (pipe[RestStg+g+1])
    );
  end

  mic_result #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[LastStg]),
    .ready_o (rdy[LastStg]),
    .pipe_i  (pipe[LastStg]),
    .valid_o (rsp_o.valid),
    .ready_i (rsp_o.ready),
    .rsp_o   (rsp)
  );

  assign rsp_o.rank            = rsp.rank;
  assign rsp_o.out_a           = rsp.a;
  assign rsp_o.out_b           = rsp.b;
  assign rsp_o.out_c           = rsp.c;
  assign rsp_o.total_degree    = rsp.deg;
  assign rsp_o.count_of_degree = rsp.cnt;
  assign rsp_o.count_upto      = rsp.upto;
  assign rsp_o.out_of_range    = rsp.oor;

endmodule
